// ----- rtl/mcs_queue_lock_manager_unit_defines.svh -----
// ----------------------------------------------------------------------------
// MCS queue lock manager assertion macros
// Shared property forms for the checks in the top level.
// ----------------------------------------------------------------------------
`ifndef MCS_QUEUE_LOCK_MANAGER_UNIT_DEFINES_SVH
`define MCS_QUEUE_LOCK_MANAGER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCSQLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcs lock manager: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MCSQLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcs lock manager: next-cycle check failed");

`endif

// ----- rtl/mcsqlm_pkg.sv -----
// ----------------------------------------------------------------------------
// MCS queue lock manager package
// Sizes, codes and the structs shared by the lock manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsqlm_pkg;

    localparam int RANKS    = 16;
    localparam int RANK_W   = 4;
    localparam int PTR_W    = RANK_W + 1;
    localparam int STATUS_W = 8;

    // A rank pointer with its top bit set means "no rank".
    localparam logic [PTR_W-1:0] PTR_NIL = {1'b1, {RANK_W{1'b0}}};

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_QUEUED     = 2'd1,
        ERR_NOT_HOLDER = 2'd2
    } err_t;

    typedef enum logic {
        LK_IDLE,
        LK_EXEC
    } lk_state_t;

    typedef struct packed {
        logic              rd_en;
        logic [RANK_W-1:0] rd_addr;
        logic              wr_en;
        logic [RANK_W-1:0] wr_addr;
        logic [PTR_W-1:0]  wr_data;
    } link_req_t;

    typedef struct packed {
        logic                grant_valid;
        logic [RANK_W-1:0]   granted_rank;
        logic [STATUS_W-1:0] granted_status;
        logic                holder_alone;
        err_t                error_code;
    } lock_res_t;

endpackage

`default_nettype wire

// ----- rtl/mcsqlm_link_mem.sv -----
// ----------------------------------------------------------------------------
// MCS successor link memory
// One entry per rank holding the rank queued behind it; one write and one
// registered read per cycle. Entries never written read back as no rank.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsqlm_link_mem (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mcsqlm_pkg::link_req_t        req,
    output logic [mcsqlm_pkg::PTR_W-1:0]      rd_link
);

    logic [mcsqlm_pkg::PTR_W-1:0] link_mem [mcsqlm_pkg::RANKS];
    logic [mcsqlm_pkg::RANKS-1:0] written_reg;
    logic [mcsqlm_pkg::PTR_W-1:0] rd_data_reg;
    logic                         rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            link_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= link_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_addr];
            end
        end
    end

    assign rd_link = rd_written_reg ? rd_data_reg : mcsqlm_pkg::PTR_NIL;

endmodule

`default_nettype wire

// ----- rtl/mcsqlm_core.sv -----
// ----------------------------------------------------------------------------
// MCS lock control core
// Holds the lock holder, queue tail and queued flags, sequences each request
// through a link memory read and applies the acquire or release update.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsqlm_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                action,
    input  wire logic [mcsqlm_pkg::RANK_W-1:0]       requester,
    input  wire logic [mcsqlm_pkg::STATUS_W-1:0]     pass_status,
    input  wire logic [mcsqlm_pkg::STATUS_W-1:0]     global_status_code,
    input  wire logic                                out_free,
    output mcsqlm_pkg::link_req_t                    link_req,
    input  wire logic [mcsqlm_pkg::PTR_W-1:0]        rd_link,
    output logic                                     res_valid,
    output mcsqlm_pkg::lock_res_t                    res
);

    mcsqlm_pkg::lk_state_t                state_reg, state_next;
    logic [mcsqlm_pkg::PTR_W-1:0]         holder_reg, holder_next;
    logic [mcsqlm_pkg::PTR_W-1:0]         tail_reg, tail_next;
    logic [mcsqlm_pkg::RANKS-1:0]         queued_reg, queued_next;

    logic                                 req_action_reg;
    logic [mcsqlm_pkg::RANK_W-1:0]        req_rank_reg;
    logic [mcsqlm_pkg::STATUS_W-1:0]      req_pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mcsqlm_pkg::LK_IDLE;
            holder_reg <= mcsqlm_pkg::PTR_NIL;
            tail_reg   <= mcsqlm_pkg::PTR_NIL;
            queued_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            holder_reg <= holder_next;
            tail_reg   <= tail_next;
            queued_reg <= queued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mcsqlm_pkg::LK_IDLE && in_valid)
        begin
            req_action_reg <= action;
            req_rank_reg   <= requester;
            req_pass_reg   <= pass_status;
        end
    end

    always_comb
    begin
        logic [mcsqlm_pkg::PTR_W-1:0] rank_ptr;
        logic                         in_range;
        logic                         grant;
        logic [mcsqlm_pkg::STATUS_W-1:0] gstat;
        mcsqlm_pkg::err_t             err;

        rank_ptr = {1'b0, req_rank_reg};
        in_range = rank_ptr < mcsqlm_pkg::PTR_W'(mcsqlm_pkg::RANKS);
        grant    = 1'b0;
        gstat    = '0;
        err      = mcsqlm_pkg::ERR_OK;

        state_next  = state_reg;
        holder_next = holder_reg;
        tail_next   = tail_reg;
        queued_next = queued_reg;
        in_stall    = 1'b1;
        res_valid   = 1'b0;

        link_req.rd_en   = 1'b0;
        link_req.rd_addr = requester;
        link_req.wr_en   = 1'b0;
        link_req.wr_addr = req_rank_reg;
        link_req.wr_data = mcsqlm_pkg::PTR_NIL;

        unique case (state_reg)
            mcsqlm_pkg::LK_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    link_req.rd_en = 1'b1;
                    state_next     = mcsqlm_pkg::LK_EXEC;
                end
            end
            mcsqlm_pkg::LK_EXEC:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = mcsqlm_pkg::LK_IDLE;
                    if (!req_action_reg)
                    begin
                        if (!in_range || queued_reg[req_rank_reg])
                        begin
                            err = mcsqlm_pkg::ERR_QUEUED;
                        end
                        else
                        begin
                            // A rank that is not queued already has a null link.
                            queued_next[req_rank_reg] = 1'b1;
                            tail_next = rank_ptr;
                            if (tail_reg[mcsqlm_pkg::PTR_W-1])
                            begin
                                holder_next = rank_ptr;
                                grant       = 1'b1;
                                gstat       = global_status_code;
                            end
                            else
                            begin
                                link_req.wr_en   = 1'b1;
                                link_req.wr_addr = tail_reg[mcsqlm_pkg::RANK_W-1:0];
                                link_req.wr_data = rank_ptr;
                            end
                        end
                    end
                    else
                    begin
                        if (!in_range || holder_reg != rank_ptr)
                        begin
                            err = mcsqlm_pkg::ERR_NOT_HOLDER;
                        end
                        else
                        begin
                            queued_next[req_rank_reg] = 1'b0;
                            link_req.wr_en = 1'b1;
                            if (rd_link[mcsqlm_pkg::PTR_W-1])
                            begin
                                holder_next = mcsqlm_pkg::PTR_NIL;
                                tail_next   = mcsqlm_pkg::PTR_NIL;
                            end
                            else
                            begin
                                holder_next = rd_link;
                                grant       = 1'b1;
                                gstat       = req_pass_reg;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = mcsqlm_pkg::LK_IDLE;
            end
        endcase

        // The holder has no successor exactly when it is also the tail.
        res.grant_valid    = grant;
        res.granted_rank   = holder_next[mcsqlm_pkg::PTR_W-1] ?
                             '0 : holder_next[mcsqlm_pkg::RANK_W-1:0];
        res.granted_status = gstat;
        res.holder_alone   = !holder_next[mcsqlm_pkg::PTR_W-1] &&
                             (holder_next == tail_next);
        res.error_code     = err;
    end

endmodule

`default_nettype wire

// ----- rtl/mcs_queue_lock_manager_unit.sv -----
// ----------------------------------------------------------------------------
// MCS queue lock manager
// Central queue lock that grants, queues and hands over ownership among ranks.
// ----------------------------------------------------------------------------
// Each request is handled in the idle and execute states: on acceptance the
// requester's successor link is read from the link memory, and in the execute
// state, once the output is free, the update is applied and the result register
// loaded. The block takes no new request until the current one is applied. The
// result register lets a new request enter while an earlier result waits to
// be taken. Every request yields exactly one result.
`default_nettype none

`include "mcs_queue_lock_manager_unit_defines.svh"

module mcs_queue_lock_manager_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mcsqlm_pkg::STATUS_W-1:0]     cfg_wr_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                action,
    input  wire logic [mcsqlm_pkg::RANK_W-1:0]       requester,
    input  wire logic [mcsqlm_pkg::STATUS_W-1:0]     pass_status,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     grant_valid,
    output logic [mcsqlm_pkg::RANK_W-1:0]            granted_rank,
    output logic [mcsqlm_pkg::STATUS_W-1:0]          granted_status,
    output logic                                     holder_alone,
    output logic [1:0]                               error_code
);

    logic [mcsqlm_pkg::STATUS_W-1:0] gsc_reg;
    logic                            out_valid_reg;
    mcsqlm_pkg::lock_res_t           res_reg;

    mcsqlm_pkg::link_req_t           link_req;
    logic [mcsqlm_pkg::PTR_W-1:0]    rd_link;
    logic                            res_valid;
    mcsqlm_pkg::lock_res_t           res;
    logic                            out_free;

    assign out_free = !out_valid_reg || !out_stall;

    mcsqlm_core u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .requester          (requester),
        .pass_status        (pass_status),
        .global_status_code (gsc_reg),
        .out_free           (out_free),
        .link_req           (link_req),
        .rd_link            (rd_link),
        .res_valid          (res_valid),
        .res                (res)
    );

    mcsqlm_link_mem u_link_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (link_req),
        .rd_link (rd_link)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gsc_reg <= cfg_wr_data;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign grant_valid    = res_reg.grant_valid;
    assign granted_rank   = res_reg.granted_rank;
    assign granted_status = res_reg.granted_status;
    assign holder_alone   = res_reg.holder_alone;
    assign error_code     = res_reg.error_code;

    // A failed request never grants and carries no status byte.
    `MCSQLM_ASSERT_NOW(a_err_no_grant, clk, rst_n,
        out_valid && (error_code != mcsqlm_pkg::ERR_OK), !grant_valid)
    `MCSQLM_ASSERT_NOW(a_no_grant_no_status, clk, rst_n,
        out_valid && !grant_valid, granted_status == '0)
    // A request in flight blocks the next one in the cycle after its acceptance.
    `MCSQLM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire
